@@ rtl/urav_pkg.sv @@
`default_nettype none
package urav_pkg;

  localparam int PULSE_BITS   = 20;
  localparam int WARMUP_READS = 2;
  localparam int SUM_BITS     = 26;
  localparam int DIVD_BITS    = SUM_BITS + 1;
  localparam int DIVS_BITS    = 9;
  localparam int Q8_BITS      = 18;
  localparam int PROD_BITS    = PULSE_BITS + 24;
  localparam int Q8_FULL_BITS = PROD_BITS + 1 - 16;

  localparam logic [1:0] REG_READING_COUNT = 2'd0;
  localparam logic [1:0] REG_TRIGGER_TICKS = 2'd1;
  localparam logic [1:0] REG_INCH_PER_TICK = 2'd2;
  localparam logic [1:0] REG_MAX_RANGE     = 2'd3;

  typedef struct packed {
    logic start_req;
    logic echo_level;
  } tick_t;

  typedef struct packed {
    logic               trigger_level;
    logic               busy_res;
    logic               reading_valid;
    logic [7:0]         reading_index;
    logic [Q8_BITS-1:0] reading_q8;
    logic               average_valid;
    logic [Q8_BITS-1:0] average_q8;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/urav_front.sv @@
`default_nettype none
module urav_front import urav_pkg::*; (
  input  wire   clk,
  input  wire   rst_n,
  input  wire   push,
  input  tick_t push_item,
  output logic  full,
  output logic  item_valid,
  output tick_t item,
  input  wire   take
);

  tick_t      mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_take;

  assign full       = (count_r == 2'd2);
  assign item_valid = (count_r != 2'd0);
  assign item       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_take    = take && item_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_item;
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_take) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_take};
    end
  end

endmodule
`default_nettype wire

@@ rtl/urav_div.sv @@
`default_nettype none
module urav_div import urav_pkg::*; (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  input  wire  [DIVD_BITS-1:0]  dividend,
  input  wire  [DIVS_BITS-1:0]  divisor,
  output logic                  done,
  output logic [DIVD_BITS-1:0]  quotient
);

  localparam int CNT_BITS = $clog2(DIVD_BITS + 1);

  logic [DIVD_BITS-1:0] quo_r;
  logic [DIVS_BITS:0]   rem_r;
  logic [DIVS_BITS-1:0] dvs_r;
  logic [CNT_BITS-1:0]  cnt_r;
  logic                 run_r;
  logic [DIVS_BITS:0]   trial;

  // shift in one dividend bit, subtract if it fits
  assign trial    = {rem_r[DIVS_BITS-1:0], quo_r[DIVD_BITS-1]};
  assign quotient = quo_r;
  assign done     = run_r && (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= CNT_BITS'(DIVD_BITS);
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      if (cnt_r == '0) begin
        run_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
        if (trial >= {1'b0, dvs_r}) begin
          rem_r <= trial - {1'b0, dvs_r};
          quo_r <= {quo_r[DIVD_BITS-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          quo_r <= {quo_r[DIVD_BITS-2:0], 1'b0};
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/urav_back.sv @@
`default_nettype none
module urav_back import urav_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         item_valid,
  input  tick_t       item,
  output logic        take,
  input  wire         cfg_valid,
  input  wire  [1:0]  cfg_index,
  input  wire  [23:0] cfg_data,
  output logic        res_empty,
  output res_t        res,
  input  wire         res_pop
);

  typedef enum logic [1:0] {PH_IDLE, PH_TRIG, PH_WAIT, PH_HIGH} phase_t;
  typedef enum logic [2:0] {SQ_TAKE, SQ_SCALE, SQ_CHECK, SQ_DIV, SQ_EMIT} seq_t;

  logic [7:0]              rc_r, tt_r;
  logic [23:0]             ipt_r;
  logic [Q8_BITS-1:0]      max_r;
  phase_t                  phase_r, phase_nxt;
  seq_t                    seq_r;
  logic [7:0]              timer_r, timer_nxt;
  logic [PULSE_BITS-1:0]   pulse_r, pulse_nxt;
  logic [1:0]              warm_r;
  logic [7:0]              acc_r;
  logic [SUM_BITS-1:0]     sum_r;
  logic [PROD_BITS-1:0]    prod_r;
  logic [Q8_FULL_BITS-1:0] q8_r;
  res_t                    hold_r, tick_res;
  logic                    out_valid_r;
  res_t                    out_r;
  logic                    slot_free, falling, run_reset;
  logic [7:0]              len, timer_inc;
  logic [PROD_BITS:0]      rounded;
  logic [7:0]              acc_inc, need;
  logic [DIVS_BITS-1:0]    n_div;
  logic [SUM_BITS-1:0]     sum_inc;
  logic                    div_start, div_done;
  logic [DIVD_BITS-1:0]    div_q, dividend;

  assign slot_free = !out_valid_r || res_pop;
  assign res_empty = !out_valid_r;
  assign res       = out_r;
  assign falling   = (phase_r == PH_HIGH) && !item.echo_level;
  assign take      = (seq_r == SQ_TAKE) && item_valid && (falling || slot_free);
  assign len       = (tt_r == 8'd0) ? 8'd1 : tt_r;
  assign timer_inc = timer_r + 8'd1;

  // one tick that does not end a measurement
  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    pulse_nxt = pulse_r;
    run_reset = 1'b0;
    tick_res  = '0;
    case (phase_r)
      PH_IDLE: if (item.start_req) begin
        phase_nxt = PH_TRIG;
        timer_nxt = 8'd0;
        pulse_nxt = '0;
        run_reset = 1'b1;
      end
      PH_TRIG: begin
        tick_res.trigger_level = 1'b1;
        if (timer_inc >= len) begin
          phase_nxt = PH_WAIT;
          timer_nxt = 8'd0;
        end else begin
          timer_nxt = timer_inc;
        end
      end
      PH_WAIT: if (item.echo_level) begin
        pulse_nxt = PULSE_BITS'(1);
        phase_nxt = PH_HIGH;
      end
      PH_HIGH: if (pulse_r != '1) pulse_nxt = pulse_r + 1'b1;
      default: phase_nxt = PH_IDLE;
    endcase
    tick_res.busy_res = (phase_nxt != PH_IDLE);
  end

  assign rounded  = {1'b0, prod_r} + (PROD_BITS+1)'(32'h8000);
  assign acc_inc  = acc_r + 8'd1;
  assign need     = (rc_r == 8'd0) ? 8'd1 : rc_r;
  assign n_div    = (acc_inc == 8'd0) ? 9'd256 : {1'b0, acc_inc};
  assign sum_inc  = sum_r + SUM_BITS'(q8_r[Q8_BITS-1:0]);
  assign dividend = {1'b0, sum_inc} + DIVD_BITS'(n_div[DIVS_BITS-1:1]);
  assign div_start = (seq_r == SQ_CHECK) && (warm_r >= 2'(WARMUP_READS))
                   && (q8_r <= Q8_FULL_BITS'(max_r))
                   && ((acc_inc >= need) || (acc_inc == 8'd0));

  urav_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (n_div),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r        <= 8'd1;
      tt_r        <= 8'd10;
      ipt_r       <= 24'd113278;
      max_r       <= 18'd97280;
      phase_r     <= PH_IDLE;
      seq_r       <= SQ_TAKE;
      timer_r     <= 8'd0;
      pulse_r     <= '0;
      warm_r      <= 2'd0;
      acc_r       <= 8'd0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_READING_COUNT: rc_r  <= cfg_data[7:0];
          REG_TRIGGER_TICKS: tt_r  <= cfg_data[7:0];
          REG_INCH_PER_TICK: ipt_r <= cfg_data;
          REG_MAX_RANGE:     max_r <= cfg_data[Q8_BITS-1:0];
          default: ;
        endcase
      end
      if (res_pop && out_valid_r) out_valid_r <= 1'b0;
      case (seq_r)
        SQ_TAKE: if (take) begin
          if (falling) begin
            prod_r <= PROD_BITS'(pulse_r) * PROD_BITS'(ipt_r);
            seq_r  <= SQ_SCALE;
          end else begin
            phase_r     <= phase_nxt;
            timer_r     <= timer_nxt;
            pulse_r     <= pulse_nxt;
            out_r       <= tick_res;
            out_valid_r <= 1'b1;
            if (run_reset) begin
              warm_r <= 2'd0;
              acc_r  <= 8'd0;
              sum_r  <= '0;
            end
          end
        end
        SQ_SCALE: begin
          q8_r  <= rounded[PROD_BITS:16];
          seq_r <= SQ_CHECK;
        end
        SQ_CHECK: begin
          pulse_r <= '0;
          timer_r <= 8'd0;
          hold_r  <= '0;
          hold_r.busy_res <= 1'b1;
          phase_r <= PH_TRIG;
          seq_r   <= SQ_EMIT;
          if (warm_r < 2'(WARMUP_READS)) begin
            warm_r <= warm_r + 2'd1;
          end else if (q8_r <= Q8_FULL_BITS'(max_r)) begin
            acc_r <= acc_inc;
            sum_r <= sum_inc;
            hold_r.reading_valid <= 1'b1;
            hold_r.reading_index <= acc_inc;
            hold_r.reading_q8    <= q8_r[Q8_BITS-1:0];
            if (div_start) begin
              hold_r.busy_res      <= 1'b0;
              hold_r.average_valid <= 1'b1;
              phase_r <= PH_IDLE;
              seq_r   <= SQ_DIV;
            end
          end
        end
        SQ_DIV: if (div_done) begin
          hold_r.average_q8 <= div_q[Q8_BITS-1:0];
          seq_r <= SQ_EMIT;
        end
        SQ_EMIT: if (slot_free) begin
          out_r       <= hold_r;
          out_valid_r <= 1'b1;
          seq_r       <= SQ_TAKE;
        end
        default: seq_r <= SQ_TAKE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/ultrasonic_range_averager_core.sv @@
`default_nettype none
// Ultrasonic range averager: one input transaction per sensor tick carries the
// start request and the sampled echo level; one result transaction per tick
// gives the trigger drive, busy flag, any accepted reading and the run average.
// Input side is a queue: push while full is low. Result side is a queue: the
// oldest result is on out_* while out_empty is low, taken with out_pop.
// A two-entry input queue parts the input side from the sequencer, and a
// one-entry result register parts the sequencer from the receiver, so ticks
// keep being queued while a result waits.
// Ordinary ticks are handled in the take state alone. The tick on which
// the echo falls passes through scale multiply, rounding, range check and
// result, plus a division when it closes the run: the mean comes from a
// bit-serial divider that resolves one quotient bit per cycle.
// Configuration writes (cfg_valid, cfg_index, cfg_data) are always ready.
// The user makes them while the block is idle; the block does not enforce it.
// Synchronous reset clears both queues, returns to idle and loads the register
// defaults. A stalled receiver holds the sequencer, then the input queue fills.
module ultrasonic_range_averager_core import urav_pkg::*; (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_push,
  output logic               in_full,
  input  wire                in_start_req,
  input  wire                in_echo_level,
  output logic               out_empty,
  input  wire                out_pop,
  output logic               out_trigger_level,
  output logic               out_busy_res,
  output logic               out_reading_valid,
  output logic [7:0]         out_reading_index,
  output logic [Q8_BITS-1:0] out_reading_q8,
  output logic               out_average_valid,
  output logic [Q8_BITS-1:0] out_average_q8,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [1:0]         cfg_index,
  input  wire  [23:0]        cfg_data
);

  tick_t push_item, item;
  logic  item_valid, take;
  res_t  res;

  assign push_item.start_req  = in_start_req;
  assign push_item.echo_level = in_echo_level;
  assign cfg_ready = 1'b1;

  urav_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_push),
    .push_item  (push_item),
    .full       (in_full),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  urav_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .res_empty  (out_empty),
    .res        (res),
    .res_pop    (out_pop)
  );

  assign out_trigger_level = res.trigger_level;
  assign out_busy_res      = res.busy_res;
  assign out_reading_valid = res.reading_valid;
  assign out_reading_index = res.reading_index;
  assign out_reading_q8    = res.reading_q8;
  assign out_average_valid = res.average_valid;
  assign out_average_q8    = res.average_q8;

endmodule
`default_nettype wire
